// File: src/ils_pkg.sv
`timescale 1ns / 1ps

package ils_pkg;

  localparam int DEF_CAPACITY = 256;

  localparam logic [2:0] MODE_READ = 3'd0;
  localparam logic [2:0] MODE_HEAD = 3'd1;
  localparam logic [2:0] MODE_TAIL = 3'd2;
  localparam logic [2:0] MODE_AT   = 3'd3;
  localparam logic [2:0] MODE_DEL  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [31:0] NONE_VALUE = 32'hFFFF_FFFF;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic judge;
    logic rd_pos;
    logic sh_init;
    logic sh_rd;
    logic sh_wr;
    logic ins_wr;
    logic len_dec;
    logic emit;
  } ils_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic do_read;
    logic do_ins;
    logic do_del;
    logic shift_more;
    logic out_free;
  } ils_stat_t;

endpackage

// File: src/indexed_list_store.sv
// Sequence: a request is taken in idle and judged; a read fetches its entry, an insert
//   or delete shifts entries, and the result is registered once the output is free.
// One request is in flight at a time; the next is taken in the cycle after the result is
//   registered. The shift costs one memory read and one write per moved entry.
// Reset: length and out_valid clear; list entries are not cleared and need no sweep.
`timescale 1ns / 1ps

module indexed_list_store
  import ils_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic [8:0]         position,
  input  logic signed [31:0] item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] read_value,
  output logic [1:0]         status,
  output logic [8:0]         list_length
);

  ils_cmd_t  cmd;
  ils_stat_t stat;

  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ils_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (mode),
    .position    (position),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .status      (status),
    .list_length (list_length)
  );

endmodule

// File: src/ils_datapath.sv
`timescale 1ns / 1ps

module ils_datapath
  import ils_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  ils_cmd_t           cmd,
  output ils_stat_t          stat,
  input  logic [2:0]         mode,
  input  logic [8:0]         position,
  input  logic signed [31:0] item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] read_value,
  output logic [1:0]         status,
  output logic [8:0]         list_length
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = (LW > 9) ? LW : 9;
  localparam logic [PW-1:0] CAP_W = PW'(CAPACITY);

  logic [31:0]   mem [CAPACITY];
  logic [2:0]    op_mode;
  logic [PW-1:0] op_pos;
  logic [31:0]   op_value;
  logic [LW-1:0] length;
  logic [PW-1:0] ptr;
  logic [31:0]   rdata;
  logic [1:0]    st_code;

  logic [PW-1:0] len_w;
  logic [PW-1:0] pos_sel;
  logic [PW-1:0] ptr_p1;
  logic [PW-1:0] ptr_m1;
  logic          is_read;
  logic          is_ins;
  logic          is_del;
  logic          range_err;
  logic          full;
  logic [1:0]    st_calc;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  assign len_w  = PW'(length);
  assign ptr_p1 = ptr + PW'(1);
  assign ptr_m1 = ptr - PW'(1);

  always_comb begin
    priority case (mode)
      MODE_HEAD: pos_sel = '0;
      MODE_TAIL: pos_sel = len_w;
      default:   pos_sel = PW'(position);
    endcase
  end

  assign is_read = (op_mode == MODE_READ);
  assign is_del  = (op_mode == MODE_DEL);
  assign is_ins  = (op_mode == MODE_HEAD) || (op_mode == MODE_TAIL) || (op_mode == MODE_AT);
  assign full    = (len_w >= CAP_W);

  always_comb begin
    if (is_read || is_del) begin
      range_err = (op_pos >= len_w);
    end else if (op_mode == MODE_AT) begin
      range_err = (op_pos > len_w);
    end else begin
      range_err = 1'b0;
    end
  end

  always_comb begin
    priority if (range_err) begin
      st_calc = ST_RANGE;
    end else if (is_ins && full) begin
      st_calc = ST_FULL;
    end else begin
      st_calc = ST_OK;
    end
  end

  assign stat.do_read    = is_read && !range_err;
  assign stat.do_ins     = is_ins && !range_err && !full;
  assign stat.do_del     = is_del && !range_err;
  assign stat.shift_more = is_del ? (ptr_p1 < len_w) : (ptr > op_pos);
  assign stat.out_free   = !out_valid || !out_stall;

  // insert moves entries up from the top, delete moves them down from the hole
  assign rd_en   = cmd.rd_pos || cmd.sh_rd;
  assign rd_addr = cmd.rd_pos ? op_pos[AW-1:0] : (is_del ? ptr_p1[AW-1:0] : ptr_m1[AW-1:0]);
  assign wr_en   = cmd.sh_wr || cmd.ins_wr;
  assign wr_addr = cmd.ins_wr ? op_pos[AW-1:0] : ptr[AW-1:0];
  assign wr_data = cmd.ins_wr ? op_value : rdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode  <= mode;
      op_pos   <= pos_sel;
      op_value <= item_value;
    end
    if (cmd.judge) begin
      st_code <= st_calc;
    end
    if (cmd.sh_init) begin
      ptr <= is_del ? op_pos : len_w;
    end else if (cmd.sh_wr) begin
      ptr <= is_del ? ptr_p1 : ptr_m1;
    end
    if (cmd.emit) begin
      read_value  <= (is_read && st_code == ST_OK) ? $signed(rdata) : $signed(NONE_VALUE);
      status      <= st_code;
      list_length <= len_w[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ins_wr) begin
        length <= length + LW'(1);
      end else if (cmd.len_dec) begin
        length <= length - LW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (rst) len_w <= CAP_W)
    else $error("list length exceeds capacity");

  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_wr |=> (len_w == $past(len_w) + PW'(1)))
    else $error("insert did not grow the list by one");

  a_emit_free: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> stat.out_free)
    else $error("result written over a pending result");

  a_shift_addr: assert property (@(posedge clk) disable iff (rst) cmd.sh_wr |-> (ptr < CAP_W))
    else $error("shift write beyond capacity");
`endif

endmodule

// File: src/ils_ctrl.sv
`timescale 1ns / 1ps

module ils_ctrl
  import ils_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  ils_stat_t stat,
  output ils_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_SH_RD  = 5'b00100,
    S_SH_WR  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.judge = 1'b1;
        priority if (stat.do_read) begin
          cmd.rd_pos = 1'b1;
          state_next = S_FINISH;
        end else if (stat.do_ins || stat.do_del) begin
          cmd.sh_init = 1'b1;
          state_next  = S_SH_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SH_RD: begin
        priority if (stat.shift_more) begin
          cmd.sh_rd  = 1'b1;
          state_next = S_SH_WR;
        end else if (stat.do_ins) begin
          cmd.ins_wr = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.len_dec = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_SH_WR: begin
        cmd.sh_wr  = 1'b1;
        state_next = S_SH_RD;
      end
      S_FINISH: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
